/* design/csds_pkg.sv */
// Shared constants, types and command/status structs of the C-SCAN disk scheduler.
package csds_pkg;

    localparam int MAX_REQ     = 32;
    localparam int TRACK_BITS  = 16;
    localparam int TRACK_W     = 16;
    localparam int MOVE_W      = 18;
    localparam int CNT_W       = $clog2(MAX_REQ + 1);
    localparam int IDX_W       = (MAX_REQ > 1) ? $clog2(MAX_REQ) : 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 40;
    localparam int M_PAD_W     = M_TDATA_W - TRACK_W - MOVE_W;

    localparam logic [CFG_IDX_W-1:0] REG_TOP_TRACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_HEAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_UP   = 2'd2;

    localparam logic [TRACK_BITS-1:0] TOP_TRACK_RST = TRACK_BITS'(199);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_SEARCH,
        ST_PASS1,
        ST_BOUND1,
        ST_BOUND2,
        ST_PASS2
    } state_t;

    typedef enum logic [1:0] {
        SEL_REQ,
        SEL_TOP,
        SEL_ZERO
    } visit_sel_t;

    typedef struct packed {
        logic             load;
        logic             start;
        logic             emit;
        visit_sel_t       sel;
        logic             boundary;
        logic             last;
        logic             done;
        logic [IDX_W-1:0] rd_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             rd_lt;
        logic             sweep_up;
        logic             out_free;
    } dp_stat_t;

endpackage

/* design/csds_ctrl.sv */
// Controller of the C-SCAN scheduler: batch phases, split search and service order indexes.
module csds_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    input  csds_pkg::dp_stat_t  stat,
    output csds_pkg::dp_cmd_t   cmd
);
    import csds_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] split_reg, split_next;

    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] pos_inc, pos_dec, req_idx;
    logic             up, more1, more2, last2, bound2_last;

    assign up          = stat.sweep_up;
    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid         = mid_sum[CNT_W:1];
    assign pos_inc     = pos_reg + CNT_W'(1);
    assign pos_dec     = pos_reg - CNT_W'(1);
    // Descending passes keep pos one above the entry being served.
    assign req_idx     = up ? pos_reg : pos_dec;
    assign more1       = up ? (pos_reg < stat.count) : (pos_reg != '0);
    assign more2       = up ? (pos_reg < split_reg) : (pos_reg > split_reg);
    assign last2       = up ? (pos_inc == split_reg) : (pos_dec == split_reg);
    assign bound2_last = up ? (split_reg == '0) : (split_reg == stat.count);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            lo_reg    <= '0;
            hi_reg    <= '0;
            pos_reg   <= '0;
            split_reg <= '0;
        end else begin
            state_reg <= state_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            pos_reg   <= pos_next;
            split_reg <= split_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pos_next   = pos_reg;
        split_next = split_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid && s_tlast) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                lo_next    = '0;
                hi_next    = stat.count;
                state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                // Lower-bound binary search: first entry not below the head.
                if (lo_reg < hi_reg) begin
                    if (stat.rd_lt) begin
                        lo_next = mid + CNT_W'(1);
                    end else begin
                        hi_next = mid;
                    end
                end else begin
                    split_next = lo_reg;
                    pos_next   = lo_reg;
                    state_next = ST_PASS1;
                end
            end
            ST_PASS1: begin
                if (more1) begin
                    if (stat.out_free) begin
                        pos_next = up ? pos_inc : pos_dec;
                    end
                end else begin
                    state_next = ST_BOUND1;
                end
            end
            ST_BOUND1: begin
                if (stat.out_free) begin
                    state_next = ST_BOUND2;
                end
            end
            ST_BOUND2: begin
                if (stat.out_free) begin
                    if (bound2_last) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_PASS2;
                        pos_next   = up ? '0 : stat.count;
                    end
                end
            end
            ST_PASS2: begin
                if (more2) begin
                    if (stat.out_free) begin
                        pos_next = up ? pos_inc : pos_dec;
                        if (last2) begin
                            state_next = ST_LOAD;
                        end
                    end
                end else begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        cmd        = '0;
        cmd.sel    = SEL_REQ;
        cmd.rd_idx = req_idx[IDX_W-1:0];
        s_tready   = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_START: begin
                cmd.start = 1'b1;
            end
            ST_SEARCH: begin
                cmd.rd_idx = mid[IDX_W-1:0];
            end
            ST_PASS1: begin
                cmd.emit = more1 && stat.out_free;
            end
            ST_BOUND1: begin
                cmd.emit     = stat.out_free;
                cmd.sel      = up ? SEL_TOP : SEL_ZERO;
                cmd.boundary = 1'b1;
            end
            ST_BOUND2: begin
                cmd.emit     = stat.out_free;
                cmd.sel      = up ? SEL_ZERO : SEL_TOP;
                cmd.boundary = 1'b1;
                cmd.last     = bound2_last;
                cmd.done     = stat.out_free && bound2_last;
            end
            ST_PASS2: begin
                cmd.emit = more2 && stat.out_free;
                cmd.last = last2;
                cmd.done = !more2 || (stat.out_free && last2);
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* design/csds_datapath.sv */
// Datapath of the C-SCAN scheduler: sorted request store, registers, movement sum, result register.
module csds_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [csds_pkg::TRACK_W-1:0]    track,
    input  logic                            cfg_wr_en,
    input  logic [csds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csds_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  csds_pkg::dp_cmd_t               cmd,
    output csds_pkg::dp_stat_t              stat,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [csds_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import csds_pkg::*;

    logic [TRACK_BITS-1:0] top_track_reg, start_head_reg;
    logic                  sweep_up_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [TRACK_BITS-1:0] req_reg  [MAX_REQ];
    logic [TRACK_BITS-1:0] req_next [MAX_REQ];
    logic [MAX_REQ-1:0]    gt;
    logic [TRACK_BITS-1:0] trk;
    logic                  ins_en;

    logic [TRACK_BITS-1:0] head_reg;
    logic [MOVE_W-1:0]     sum_reg, sum_next;
    logic [TRACK_BITS-1:0] head_clamp, rd_raw, rd_val, visit, step_len;

    logic [TRACK_BITS-1:0] out_track_reg;
    logic [MOVE_W-1:0]     out_sum_reg;
    logic                  out_bnd_reg, out_last_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  out_free;

    assign trk    = track[TRACK_BITS-1:0];
    assign ins_en = cmd.load && (count_reg != CNT_W'(MAX_REQ));

    // Each entry either keeps its value, takes its lower neighbor, or takes the new track.
    for (genvar g = 0; g < MAX_REQ; g++) begin : g_slot
        localparam logic [CNT_W-1:0] SLOT = CNT_W'(g);
        assign gt[g] = (SLOT < count_reg) && (req_reg[g] > trk);
        if (g == 0) begin : g_first
            assign req_next[g] = (gt[g] || SLOT == count_reg) ? trk : req_reg[g];
        end else begin : g_rest
            assign req_next[g] = gt[g-1] ? req_reg[g-1] :
                                 (gt[g] || SLOT == count_reg) ? trk : req_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (ins_en) begin
            req_reg <= req_next;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.done) begin
            count_next = '0;
        end else if (ins_en) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_track_reg  <= TOP_TRACK_RST;
            start_head_reg <= '0;
            sweep_up_reg   <= 1'b1;
            count_reg      <= '0;
        end else begin
            count_reg <= count_next;
            if (cfg_wr_en && cfg_index == REG_TOP_TRACK) begin
                top_track_reg <= cfg_wdata[TRACK_BITS-1:0];
            end
            if (cfg_wr_en && cfg_index == REG_START_HEAD) begin
                start_head_reg <= cfg_wdata[TRACK_BITS-1:0];
            end
            if (cfg_wr_en && cfg_index == REG_SWEEP_UP) begin
                sweep_up_reg <= cfg_wdata[0];
            end
        end
    end

    // Clamping is monotone, so the stored order still holds after clamping on read.
    assign head_clamp = (start_head_reg > top_track_reg) ? top_track_reg : start_head_reg;
    assign rd_raw     = req_reg[cmd.rd_idx];
    assign rd_val     = (rd_raw > top_track_reg) ? top_track_reg : rd_raw;

    always_comb begin
        case (cmd.sel)
            SEL_REQ:  visit = rd_val;
            SEL_TOP:  visit = top_track_reg;
            SEL_ZERO: visit = '0;
            default:  visit = '0;
        endcase
    end

    assign step_len = (head_reg >= visit) ? (head_reg - visit) : (visit - head_reg);
    assign sum_next = sum_reg + MOVE_W'(step_len);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            sum_reg  <= '0;
        end else if (cmd.start) begin
            head_reg <= head_clamp;
            sum_reg  <= '0;
        end else if (cmd.emit) begin
            head_reg <= visit;
            sum_reg  <= sum_next;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_track_reg <= visit;
            out_sum_reg   <= sum_next;
            out_bnd_reg   <= cmd.boundary;
            out_last_reg  <= cmd.last;
        end
    end

    assign stat.count    = count_reg;
    assign stat.rd_lt    = rd_val < head_clamp;
    assign stat.sweep_up = sweep_up_reg;
    assign stat.out_free = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_sum_reg, TRACK_W'(out_track_reg)};
    assign m_tuser  = out_bnd_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* design/circular_scan_disk_scheduler.sv */
// Top level of the C-SCAN disk scheduler: controller, datapath and checks.
// Loading: one request per cycle, inserted into the sorted register store in the cycle it transfers.
// After the request marked last: a setup state, then a binary search for the head split,
// then n+2 results for n stored requests at one per cycle while the result register is
// free, with none where the first pass ends; the result register sets the output rate.
// Reset (aresetn, synchronous, active low) empties the batch and restores the register
// defaults (top track 199, start head 0, sweep up); the request store is not cleared.
module circular_scan_disk_scheduler (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [csds_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] track
    input  logic                            s_tlast,   // last_request
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [csds_pkg::M_TDATA_W-1:0]  m_tdata,   // [15:0] visit_track, [33:16] total_movement
    output logic                            m_tuser,   // [0] is_boundary
    output logic                            m_tlast,   // last_visit
    input  logic                            cfg_wr_en,
    input  logic [csds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csds_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import csds_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    csds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csds_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .track     (s_tdata[TRACK_W-1:0]),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // A final request ends loading until the whole batch has been scheduled.
    a_last_stops_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still ready after the final request of a batch");

    // A result never overwrites one that has not been transferred.
    a_emit_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("result issued while the result register is occupied");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count <= CNT_W'(MAX_REQ))
        else $error("request count beyond store depth");

    a_no_load_while_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !cmd.emit && !cmd.start)
        else $error("request loaded while a batch is being scheduled");

endmodule

/* bench/csds_checker.sv */
// Checker of the C-SCAN disk scheduler: predicts the service order of each batch and compares results.
module csds_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [csds_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] track
    input  logic                            s_tlast,   // last_request
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [csds_pkg::M_TDATA_W-1:0]  m_tdata,   // [15:0] visit_track, [33:16] total_movement
    input  logic                            m_tuser,   // [0] is_boundary
    input  logic                            m_tlast,   // last_visit
    input  logic                            cfg_wr_en,
    input  logic [csds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csds_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              pending
);
    import csds_pkg::*;

    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic               boundary;
        logic [MOVE_W-1:0]  movement;
        logic               last;
    } visit_t;

    logic [TRACK_W-1:0] top_track;
    logic [TRACK_W-1:0] start_head;
    logic               sweep_up;

    logic [TRACK_W-1:0] req_store [MAX_REQ];
    int                 req_count;
    logic [TRACK_W-1:0] head_pos;
    logic [MOVE_W-1:0]  moved;
    int                 visits_left;
    int                 result_index;
    visit_t             visit_q [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", result_index, msg);
        fail_count++;
    endtask

    // Requests beyond the store size are dropped, as the block does.
    task automatic insert_request(input logic [TRACK_W-1:0] trk);
        int i;
        if (req_count < MAX_REQ) begin
            i = req_count;
            while (i > 0 && req_store[i-1] > trk) begin
                req_store[i] = req_store[i-1];
                i--;
            end
            req_store[i] = trk;
            req_count++;
        end
    endtask

    task automatic add_visit(input logic [TRACK_W-1:0] trk, input logic boundary);
        visit_t v;
        moved = moved + MOVE_W'(head_pos > trk ? head_pos - trk : trk - head_pos);
        head_pos = trk;
        visits_left--;
        v.track    = trk;
        v.boundary = boundary;
        v.movement = moved;
        v.last     = (visits_left == 0);
        visit_q.push_back(v);
    endtask

    task automatic plan_service_order();
        int split;
        // Clamping happens only now, so a top track written mid-batch applies to all.
        for (int i = 0; i < req_count; i++)
            if (req_store[i] > top_track) req_store[i] = top_track;
        head_pos    = (start_head > top_track) ? top_track : start_head;
        moved       = '0;
        visits_left = req_count + 2;
        split       = 0;
        while (split < req_count && req_store[split] < head_pos) split++;
        if (sweep_up) begin
            for (int i = split; i < req_count; i++) add_visit(req_store[i], 1'b0);
            add_visit(top_track, 1'b1);
            add_visit('0, 1'b1);
            for (int i = 0; i < split; i++) add_visit(req_store[i], 1'b0);
        end else begin
            for (int i = split; i > 0; i--) add_visit(req_store[i-1], 1'b0);
            add_visit('0, 1'b1);
            add_visit(top_track, 1'b1);
            for (int i = req_count; i > split; i--) add_visit(req_store[i-1], 1'b0);
        end
        req_count = 0;
    endtask

    always @(posedge aclk) begin
        visit_t want;
        if (!aresetn) begin
            top_track  = TOP_TRACK_RST;
            start_head = '0;
            sweep_up   = 1'b1;
            req_count  = 0;
            visit_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TOP_TRACK:  top_track  = cfg_wdata[TRACK_W-1:0];
                    REG_START_HEAD: start_head = cfg_wdata[TRACK_W-1:0];
                    REG_SWEEP_UP:   sweep_up   = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                insert_request(s_tdata[TRACK_W-1:0]);
                if (s_tlast) plan_service_order();
            end
            if (m_tvalid && m_tready) begin
                if (visit_q.size() == 0) begin
                    report_mismatch($sformatf("no visit expected, got track %0d",
                                              m_tdata[TRACK_W-1:0]));
                end else begin
                    want = visit_q.pop_front();
                    if (m_tdata[TRACK_W-1:0] !== want.track)
                        report_mismatch($sformatf("visit_track got %0d, want %0d",
                                                  m_tdata[TRACK_W-1:0], want.track));
                    if (m_tuser !== want.boundary)
                        report_mismatch($sformatf("is_boundary got %0b, want %0b",
                                                  m_tuser, want.boundary));
                    if (m_tdata[TRACK_W+MOVE_W-1:TRACK_W] !== want.movement)
                        report_mismatch($sformatf("total_movement got %0d, want %0d",
                                                  m_tdata[TRACK_W+MOVE_W-1:TRACK_W],
                                                  want.movement));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last_visit got %0b, want %0b",
                                                  m_tlast, want.last));
                end
                result_index++;
            end
        end
        pending = visit_q.size();
    end

endmodule

/* bench/testbench.sv */
// Testbench top of the C-SCAN disk scheduler: clock, reset, stimulus, output stalls and verdict.
module testbench;
    import csds_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 320;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [15:0] track
    logic                  s_tlast;   // last_request
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [15:0] visit_track, [33:16] total_movement
    logic                  m_tuser;   // [0] is_boundary
    logic                  m_tlast;   // last_visit
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int                    fail_count;
    int                    pending;
    int                    cycle_count = 0;
    logic [TRACK_W-1:0]    cur_top;
    bit                    no_gaps;

    circular_scan_disk_scheduler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    csds_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: runs of ready cycles and stalls, mostly short, some long.
    initial begin
        int  r;
        int  run;
        logic want_ready;
        m_tready = 1'b0;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                want_ready = 1'b1;
                run = $urandom_range(30, 120);
            end else if (r < 60) begin
                want_ready = 1'b1;
                run = $urandom_range(1, 6);
            end else if (r < 95) begin
                want_ready = 1'b0;
                run = $urandom_range(1, 3);
            end else begin
                want_ready = 1'b0;
                run = $urandom_range(10, 40);
            end
            @(negedge aclk);
            m_tready <= want_ready;
            repeat (run - 1) @(negedge aclk);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Called right after a rising edge; the next falling edge either drops
    // tvalid for a gap or presents the new request.
    task automatic send_request(input logic [TRACK_W-1:0] trk, input logic last);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= trk;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stops the input side and waits until every expected visit has arrived.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [TRACK_W-1:0] top, input logic [TRACK_W-1:0] head,
                             input logic up);
        write_reg(REG_TOP_TRACK, top);
        write_reg(REG_START_HEAD, head);
        write_reg(REG_SWEEP_UP, CFG_DATA_W'(up));
        cur_top = top;
    endtask

    function automatic logic [TRACK_W-1:0] pick_track();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return '0;
        if (r < 10) return cur_top;
        if (r < 50) return TRACK_W'($urandom_range(0, cur_top));
        return TRACK_W'($urandom);
    endfunction

    task automatic random_config();
        int r;
        logic [TRACK_W-1:0] top;
        logic [TRACK_W-1:0] head;
        r = $urandom_range(0, 99);
        if (r < 10)      top = '0;
        else if (r < 20) top = '1;
        else if (r < 50) top = TRACK_W'($urandom_range(1, 255));
        else             top = TRACK_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 15)      head = '0;
        else if (r < 30) head = top;
        else if (r < 45) head = '1;
        else if (r < 75) head = TRACK_W'($urandom_range(0, top));
        else             head = TRACK_W'($urandom);
        settle();
        configure(top, head, 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int sent;
        int r;
        int n;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        cur_top   = TOP_TRACK_RST;
        no_gaps   = 1'b0;
        sent      = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults: a lone request at track zero, then a wide track clamped to the top.
        send_request(16'd0, 1'b1);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd50, 1'b1);
        settle();

        // Largest disk with the head at its top, sweeping down: the largest movement total.
        configure(16'hFFFF, 16'hFFFF, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd30000, 1'b1);
        settle();

        // A disk of a single track, in both directions.
        configure(16'd0, 16'd0, 1'b0);
        send_request(16'd7, 1'b1);
        settle();
        configure(16'd0, 16'hFFFF, 1'b1);
        send_request(16'd0, 1'b1);
        settle();

        // Requests below the head, duplicates and one on the head itself.
        configure(16'd255, 16'd200, 1'b1);
        send_request(16'd10, 1'b0);
        send_request(16'd10, 1'b0);
        send_request(16'd200, 1'b0);
        send_request(16'd199, 1'b1);
        settle();

        // Shrinking the disk mid-batch must clamp the requests already stored.
        configure(16'd1000, 16'd500, 1'b1);
        send_request(16'd900, 1'b0);
        send_request(16'd100, 1'b0);
        send_request(16'd600, 1'b0);
        settle();
        write_reg(REG_TOP_TRACK, 16'd300);
        cur_top = 16'd300;
        send_request(16'hFFFF, 1'b1);
        settle();

        // Sweeping down with requests on both sides of the head.
        configure(16'd255, 16'd200, 1'b0);
        send_request(16'd10, 1'b0);
        send_request(16'd220, 1'b0);
        send_request(16'd200, 1'b0);
        send_request(16'd5, 1'b1);

        // Random batches; a few overfill the store so that extra requests are dropped.
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) random_config();
            r = $urandom_range(0, 99);
            if (r < 70)      n = $urandom_range(1, 8);
            else if (r < 92) n = $urandom_range(9, MAX_REQ);
            else             n = $urandom_range(MAX_REQ + 1, MAX_REQ + 4);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < n; k++) send_request(pick_track(), k == n - 1);
            sent += n;
        end

        settle();
        repeat (20) @(negedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
design/csds_pkg.sv
design/csds_ctrl.sv
design/csds_datapath.sv
design/circular_scan_disk_scheduler.sv
bench/csds_checker.sv
bench/testbench.sv
